[rtl/mslp_pkg.sv]
package mslp_pkg;

  localparam int unsigned SampleWidth = 24;
  localparam int unsigned CoefWidth   = 24;
  localparam int unsigned FracBits    = 22;
  localparam int unsigned ChanWidth   = 4;
  localparam int unsigned RegIdxWidth = 3;
  localparam int unsigned ProdWidth   = SampleWidth + CoefWidth;
  // five products, two of them subtracted: three guard bits cover the sum
  localparam int unsigned AccWidth    = ProdWidth + 3;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;

  localparam sample_t SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};

  typedef enum logic [RegIdxWidth-1:0] {
    REG_FEED_CUR    = 3'd0,
    REG_FEED_PREV   = 3'd1,
    REG_FEED_PREV2  = 3'd2,
    REG_BACK_PREV   = 3'd3,
    REG_BACK_PREV2  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    coef_t feed_cur;
    coef_t feed_prev;
    coef_t feed_prev2;
    coef_t back_prev;
    coef_t back_prev2;
  } coef_set_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  typedef struct packed {
    logic [ChanWidth-1:0] channel;
    sample_t              sample_in;
  } in_item_t;

  typedef struct packed {
    logic [ChanWidth-1:0] channel_out;
    sample_t              sample_out;
    logic                 saturated;
  } out_item_t;

endpackage

[rtl/multichannel_second_order_lowpass_core.sv]
// Multichannel biquad low-pass filter, direct form I. Each transfer carries a
// channel number and a sample; the result is a2*x + a1*x1 + a0*x2 - b1*y1 -
// b0*y2 over that channel's history, rounded half up from Q2.22, saturated to
// the sample range and flagged when clipped. The block takes one transfer per
// cycle unless the output stalls; the five multiplies, sum and saturation sit
// in the single stage between input register and result register, which also
// writes the channel history so that back-to-back samples of one channel see
// each other. A channel number at or above CHANNELS yields a zero result and
// leaves all history untouched. Coefficients reset to zero; the user must
// write them through the cfg port only while idle, unenforced by the block.
module multichannel_second_order_lowpass_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mslp_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mslp_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mslp_pkg::RegIdxWidth-1:0]     cfg_index_i,
  input  logic [mslp_pkg::CoefWidth-1:0]       cfg_wdata_i
);
  import mslp_pkg::*;

  // the channel field is four bits wide, so no more than sixteen histories
  localparam int unsigned Depth = (CHANNELS < (1 << ChanWidth)) ? CHANNELS
                                                                : (1 << ChanWidth);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  coef_set_t coef_q;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;

  sample_t x1_q [Depth];
  sample_t x2_q [Depth];
  sample_t y1_q [Depth];
  sample_t y2_q [Depth];

  logic            advance, in_range;
  logic [IdxW-1:0] idx;
  hist_t           hist_rd;
  sample_t         y;
  logic            sat;

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_range   = 32'(in_q.channel) < Depth;
  assign idx        = in_q.channel[IdxW-1:0];

  always_comb begin
    hist_rd = '0;
    if (in_range) begin
      hist_rd.x1 = x1_q[idx];
      hist_rd.x2 = x2_q[idx];
      hist_rd.y1 = y1_q[idx];
      hist_rd.y2 = y2_q[idx];
    end
  end

  mslp_datapath u_datapath (
    .coefs_i (coef_q),
    .hist_i  (hist_rd),
    .x_i     (in_q.sample_in),
    .y_o     (y),
    .sat_o   (sat)
  );

  always_comb begin
    out_d.channel_out = in_q.channel;
    out_d.sample_out  = in_range ? y : '0;
    out_d.saturated   = in_range && sat;
  end

  // coefficient registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FEED_CUR:   coef_q.feed_cur   <= cfg_wdata_i;
        REG_FEED_PREV:  coef_q.feed_prev  <= cfg_wdata_i;
        REG_FEED_PREV2: coef_q.feed_prev2 <= cfg_wdata_i;
        REG_BACK_PREV:  coef_q.back_prev  <= cfg_wdata_i;
        REG_BACK_PREV2: coef_q.back_prev2 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // shift the channel history as the result leaves the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      x2_q[idx] <= x1_q[idx];
      x1_q[idx] <= in_q.sample_in;
      y2_q[idx] <= y1_q[idx];
      y1_q[idx] <= y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sat_clips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated |->
      out_q.sample_out == SampleMax || out_q.sample_out == SampleMin)
    else $error("saturated result not at a range limit");

  a_unused_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && 32'(out_q.channel_out) >= Depth |->
      out_q.sample_out == '0 && !out_q.saturated)
    else $error("unmapped channel gave a non-zero result");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item left the input stage without a result");

  a_hist_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_range |=> y1_q[$past(idx)] == out_q.sample_out)
    else $error("output history differs from the delivered sample");

endmodule

[rtl/mslp_datapath.sv]
module mslp_datapath (
  input  mslp_pkg::coef_set_t coefs_i,
  input  mslp_pkg::hist_t     hist_i,
  input  mslp_pkg::sample_t   x_i,
  output mslp_pkg::sample_t   y_o,
  output logic                sat_o
);
  import mslp_pkg::*;

  localparam int unsigned QWidth = AccWidth - FracBits;
  localparam logic signed [AccWidth-1:0] Half = AccWidth'(1) << (FracBits - 1);
  localparam logic signed [QWidth-1:0]   QMax = QWidth'(SampleMax);
  localparam logic signed [QWidth-1:0]   QMin = QWidth'(SampleMin);

  logic signed [ProdWidth-1:0] p_cur, p_prev, p_prev2, p_bprev, p_bprev2;
  logic signed [AccWidth-1:0]  acc, rnd;
  logic signed [QWidth-1:0]    q;

  assign p_cur    = $signed(coefs_i.feed_cur)   * $signed(x_i);
  assign p_prev   = $signed(coefs_i.feed_prev)  * $signed(hist_i.x1);
  assign p_prev2  = $signed(coefs_i.feed_prev2) * $signed(hist_i.x2);
  assign p_bprev  = $signed(coefs_i.back_prev)  * $signed(hist_i.y1);
  assign p_bprev2 = $signed(coefs_i.back_prev2) * $signed(hist_i.y2);

  assign acc = AccWidth'(p_cur) + AccWidth'(p_prev) + AccWidth'(p_prev2)
             - AccWidth'(p_bprev) - AccWidth'(p_bprev2);

  // round half up, then floor by dropping the fraction bits
  assign rnd = acc + Half;
  assign q   = rnd[AccWidth-1:FracBits];

  always_comb begin
    if (q > QMax) begin
      y_o   = SampleMax;
      sat_o = 1'b1;
    end else if (q < QMin) begin
      y_o   = SampleMin;
      sat_o = 1'b1;
    end else begin
      y_o   = q[SampleWidth-1:0];
      sat_o = 1'b0;
    end
  end

endmodule
